[src/msfb_pkg.sv]
package msfb_pkg;

   // Work kinds handed from the front end to the back end.
   localparam logic [1:0] KIND_HDR  = 2'd0;  // first byte of a good packet
   localparam logic [1:0] KIND_DATA = 2'd1;  // middle payload byte
   localparam logic [1:0] KIND_LAST = 2'd2;  // last payload byte, PEC follows
   localparam logic [1:0] KIND_ERR  = 2'd3;  // bad length, one error item

   // Configuration register indexes.
   localparam logic [1:0] REG_DEST = 2'd0;
   localparam logic [1:0] REG_SRC  = 2'd1;

   localparam logic [7:0] SMBUS_CMD    = 8'h0F;
   localparam logic [7:0] MIN_PKT_LEN  = 8'd5;
   localparam int         HDR_PLUS_PEC = 5;
   localparam logic [7:0] CRC_POLY     = 8'h07;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] len;
   } msfb_entry_type;

   // CRC-8, polynomial x^8+x^2+x+1, one byte folded in.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

[src/msfb_front.sv]
module msfb_front
   import msfb_pkg::*;
#(
   parameter int FRAME_MTU = 256
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [15:0]    req_tdata,
   input  logic           q_full,
   output logic           push,
   output msfb_entry_type entry
);

   localparam logic [7:0] PKT_MAX = 8'(FRAME_MTU - HDR_PLUS_PEC);

   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       swallow_ff, swallow_in;
   logic       accept;
   logic [7:0] data_byte, packet_length;
   logic       bad_len;

   assign data_byte     = req_tdata[7:0];
   assign packet_length = req_tdata[15:8];
   assign req_tready    = !q_full;
   assign accept        = req_tvalid && req_tready;
   assign bad_len       = (packet_length < MIN_PKT_LEN) || (packet_length > PKT_MAX);

   always_comb begin
      bytes_left_in = bytes_left_ff;
      swallow_in    = swallow_ff;
      push          = 1'b0;
      entry.kind    = KIND_DATA;
      entry.data    = data_byte;
      entry.len     = packet_length;
      if (accept) begin
         priority if (bytes_left_ff == 8'd0) begin
            push = 1'b1;
            if (bad_len) begin
               entry.kind    = KIND_ERR;
               swallow_in    = packet_length > 8'd1;
               bytes_left_in = (packet_length > 8'd1) ? packet_length - 8'd1 : 8'd0;
            end else begin
               entry.kind    = KIND_HDR;
               swallow_in    = 1'b0;
               bytes_left_in = packet_length - 8'd1;
            end
         end else if (swallow_ff) begin
            // Remaining bytes of a rejected packet are dropped.
            bytes_left_in = bytes_left_ff - 8'd1;
            swallow_in    = bytes_left_ff != 8'd1;
         end else begin
            push          = 1'b1;
            entry.kind    = (bytes_left_ff == 8'd1) ? KIND_LAST : KIND_DATA;
            bytes_left_in = bytes_left_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 8'd0;
         swallow_ff    <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         swallow_ff    <= swallow_in;
      end
   end

   a_swallow_has_bytes: assert property (@(posedge clock) disable iff (reset)
      swallow_ff |-> bytes_left_ff != 8'd0)
      else $error("swallowing with no bytes left");

endmodule

[src/msfb_queue.sv]
module msfb_queue
   import msfb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  msfb_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output logic           q_valid,
   output msfb_entry_type head
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   msfb_entry_type mem [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]    count_ff, count_in;
   logic           do_push, do_pop;

   assign full    = count_ff == (AW+1)'(DEPTH);
   assign q_valid = count_ff != '0;
   assign head    = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !q_valid))
      else $error("pop from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("queue count out of range");

endmodule

[src/msfb_back.sv]
module msfb_back
   import msfb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  msfb_entry_type head,
   output logic           pop,
   input  logic [6:0]     dest_address,
   input  logic [6:0]     source_address,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,
   output logic           rsp_tlast,
   output logic [0:0]     rsp_tuser
);

   logic [2:0] step_ff, step_in;
   logic [7:0] crc_ff, crc_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       load, last_step, crc_upd, crc_restart;

   assign load = q_valid && (!valid_ff || rsp_tready);

   always_comb begin
      byte_in     = head.data;
      last_in     = 1'b0;
      err_in      = 1'b0;
      crc_upd     = 1'b0;
      crc_restart = 1'b0;
      last_step   = 1'b1;
      unique case (head.kind)
         KIND_HDR: begin
            crc_upd     = 1'b1;
            crc_restart = step_ff == 3'd0;
            last_step   = step_ff == 3'd4;
            unique case (step_ff)
               3'd0:    byte_in = {dest_address, 1'b0};
               3'd1:    byte_in = SMBUS_CMD;
               3'd2:    byte_in = head.len + 8'd1;
               3'd3:    byte_in = {source_address, 1'b1};
               default: byte_in = head.data;
            endcase
         end
         KIND_DATA: begin
            crc_upd = 1'b1;
         end
         KIND_LAST: begin
            last_step = step_ff == 3'd1;
            if (step_ff == 3'd0) begin
               crc_upd = 1'b1;
            end else begin
               byte_in = crc_ff;
               last_in = 1'b1;
            end
         end
         KIND_ERR: begin
            byte_in = 8'd0;
            last_in = 1'b1;
            err_in  = 1'b1;
         end
         default: begin
            byte_in = head.data;
         end
      endcase
   end

   assign pop = load && last_step;

   always_comb begin
      step_in  = step_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = last_step ? 3'd0 : step_ff + 3'd1;
         valid_in = 1'b1;
         if (crc_upd) begin
            crc_in = crc8_byte(crc_restart ? 8'd0 : crc_ff, byte_in);
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         crc_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = byte_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = err_ff;

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && err_ff) |-> (last_ff && byte_ff == 8'd0))
      else $error("error item not marked last or not zero");

endmodule

[src/mctp_smbus_frame_builder.sv]
// Channel  | Direction | Ports               | Contents
// ---------+-----------+---------------------+--------------------------------------------
// req      | in        | req_tvalid/tready   | tdata[7:0] data_byte, [15:8] packet_length
// rsp      | out       | rsp_tvalid/tready   | tdata out_byte, tlast frame_last,
//          |           |                     | tuser[0] length_error
// csr      | in        | csr_we/index/wdata  | 0 dest_address, 1 source_address
//
// Each input item is classified by the front end in its accept cycle and queued
// (four entries) for the back end, which emits one output item per cycle unless rsp stalls.
// A packet's first byte yields five output items (four header bytes and the byte),
// middle bytes one, the last byte two (byte and PEC), a bad length one error item.
// Input throughput is set by the back end; input stalls whenever the queue is full,
// as after a header burst or an output stall. Items pass the queue, then the output register.
// Reset is synchronous, active high; it empties the queue and loads the address defaults.
// Either side may stall independently; the output register holds its item until taken.
module mctp_smbus_frame_builder
   import msfb_pkg::*;
#(
   parameter int FRAME_MTU = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream: [7:0] data_byte, [15:8] packet_length.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // Output stream: tdata [7:0] out_byte; tuser [0] length_error.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   logic [6:0]     dest_ff, dest_in;
   logic [6:0]     src_ff, src_in;
   logic           push, pop, q_full, q_valid;
   msfb_entry_type push_entry, head;

   // Address registers; indexes beyond the register list are ignored.
   always_comb begin
      dest_in = dest_ff;
      src_in  = src_ff;
      if (csr_we) begin
         if (csr_index == REG_DEST) begin
            dest_in = csr_wdata;
         end
         if (csr_index == REG_SRC) begin
            src_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff <= 7'd68;
         src_ff  <= 7'd65;
      end else begin
         dest_ff <= dest_in;
         src_ff  <= src_in;
      end
   end

   // Front end: tracks packet position and classifies each byte.
   msfb_front #(
      .FRAME_MTU(FRAME_MTU)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .entry      (push_entry)
   );

   msfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .q_valid    (q_valid),
      .head       (head)
   );

   // Back end: expands each queued entry into frame bytes and keeps the PEC.
   msfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .head           (head),
      .pop            (pop),
      .dest_address   (dest_ff),
      .source_address (src_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser)
   );

endmodule
